FILE: hdl/msgc_pkg.sv
// Shared types and constants of the moisture sort gate controller.
package msgc_pkg;

    localparam int ADC_W    = 12;
    localparam int GAIN_W   = 17;
    localparam int OFFS_W   = 25;
    localparam int TICK_W   = 16;
    localparam int MOIST_W  = 15;
    localparam int ANGLE_W  = 8;
    localparam int CLASS_W  = 2;
    localparam int STATE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = OFFS_W;

    // Product plus intercept fits a 30-bit signed value.
    localparam int SUM_W = 30;

    localparam logic signed [SUM_W-1:0] FULL_Q16 = SUM_W'(100 * 65536);
    localparam logic [MOIST_W-1:0]      FULL_Q8  = MOIST_W'(25600);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WET      = 3'd6;

    // Register reset values.
    localparam logic signed [GAIN_W-1:0] GAIN_RST     = -17'sd1029;
    localparam logic signed [OFFS_W-1:0] OFFSET_RST   = 25'sd2975334;
    localparam logic [TICK_W-1:0]        INTERVAL_RST = 16'd3000;
    localparam logic [TICK_W-1:0]        HOLD_RST     = 16'd10000;
    localparam logic [MOIST_W-1:0]       EMPTY_RST    = 15'd1280;
    localparam logic [MOIST_W-1:0]       DRY_RST      = 15'd2560;
    localparam logic [MOIST_W-1:0]       WET_RST      = 15'd3584;

    // Moisture classes.
    localparam logic [CLASS_W-1:0] CLS_EMPTY = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_DRY   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_SAFE  = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_WET   = 2'd3;

    // Gate angles in degrees.
    localparam logic [ANGLE_W-1:0] ANGLE_LEFT   = 8'd0;
    localparam logic [ANGLE_W-1:0] ANGLE_CENTER = 8'd90;
    localparam logic [ANGLE_W-1:0] ANGLE_RIGHT  = 8'd180;

    typedef struct packed {
        logic [ADC_W-1:0] adc_average;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] servo_angle;
        logic               servo_enabled;
        logic               sample_taken;
        logic [MOIST_W-1:0] moisture_q8;
        logic [CLASS_W-1:0] moisture_class;
        logic [STATE_W-1:0] sort_state;
    } t_out_item;

    // Conversion coefficients handed to the conversion unit.
    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_q16;
        logic signed [OFFS_W-1:0] offset_q16;
    } t_conv_coef;

endpackage

FILE: hdl/msgc_chan_if.sv
// Valid/ready channel carrying one item of a given payload type.
interface msgc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/moisture_sort_gate_controller.sv
// Top level of the moisture sort gate controller: pipeline, sequencer and registers.
//
// Usage: every millisecond tick the source offers one item on i_in carrying the
// averaged 12-bit moisture reading. For every accepted item the block returns
// exactly one item on o_out with the gate angle, the servo enable, a flag that
// tells whether this tick took a sample, the last moisture in percent times 256,
// its class and the sequencer state.
// The pipeline has three registers: the input register, the converted moisture
// register (one multiply and add) and the result register, where the sample
// timer, the classing and the idle/sorting/done sequencer are updated. One item is
// taken in every cycle while the receiver does not stall; the sequencer updates
// once per item, which sets that rate. Configuration goes through a plain write
// port (enable, index, data); unknown indexes are ignored. The user must ensure
// it is written only while no item is in flight; the block does not enforce it.
// After reset the registers hold their default values, the gate is centered
// with the drive off, the sequencer is idle and the first tick takes a sample.
// When the receiver stalls, the result register holds and the earlier stages
// keep filling until the pipeline is full, after which i_in.ready drops.
module moisture_sort_gate_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    msgc_chan_if.sink                            i_in,
    msgc_chan_if.source                          o_out,
    input  logic                                 i_cfg_we,
    input  logic [msgc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [msgc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import msgc_pkg::*;

    typedef enum logic [STATE_W-1:0] {
        SEQ_IDLE    = 2'd0,
        SEQ_SORTING = 2'd1,
        SEQ_DONE    = 2'd2
    } t_seq_state;

    // Configuration registers.
    logic signed [GAIN_W-1:0] r_gain;
    logic signed [OFFS_W-1:0] r_offset;
    logic [TICK_W-1:0]        r_interval;
    logic [TICK_W-1:0]        r_hold_ticks;
    logic [MOIST_W-1:0]       r_empty_lim;
    logic [MOIST_W-1:0]       r_dry_lim;
    logic [MOIST_W-1:0]       r_wet_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain       <= GAIN_RST;
            r_offset     <= OFFSET_RST;
            r_interval   <= INTERVAL_RST;
            r_hold_ticks <= HOLD_RST;
            r_empty_lim  <= EMPTY_RST;
            r_dry_lim    <= DRY_RST;
            r_wet_lim    <= WET_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GAIN:     r_gain       <= $signed(i_cfg_data[GAIN_W-1:0]);
                REG_OFFSET:   r_offset     <= $signed(i_cfg_data[OFFS_W-1:0]);
                REG_INTERVAL: r_interval   <= i_cfg_data[TICK_W-1:0];
                REG_HOLD:     r_hold_ticks <= i_cfg_data[TICK_W-1:0];
                REG_EMPTY:    r_empty_lim  <= i_cfg_data[MOIST_W-1:0];
                REG_DRY:      r_dry_lim    <= i_cfg_data[MOIST_W-1:0];
                REG_WET:      r_wet_lim    <= i_cfg_data[MOIST_W-1:0];
                default:      ;
            endcase
        end
    end

    // Pipeline handshake. Each stage loads when it is empty or moving on.
    logic r_in_valid;
    logic r_conv_valid;
    logic r_out_valid;
    logic w_fire_conv;
    logic w_fire_seq;

    assign w_fire_seq  = r_conv_valid && (!r_out_valid || o_out.ready);
    assign w_fire_conv = r_in_valid && (!r_conv_valid || w_fire_seq);
    assign i_in.ready  = !r_in_valid || w_fire_conv;

    // Stage one: input register.
    logic [ADC_W-1:0] r_adc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_adc <= i_in.data.adc_average;
        end
    end

    // Stage two: conversion to percent times 256.
    t_conv_coef         w_coef;
    logic [MOIST_W-1:0] w_conv;
    logic [MOIST_W-1:0] r_conv;

    assign w_coef.gain_q16   = r_gain;
    assign w_coef.offset_q16 = r_offset;

    msgc_conv u_conv (
        .i_coef        (w_coef),
        .i_adc         (r_adc),
        .o_moisture_q8 (w_conv)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_valid <= 1'b0;
        end else if (!r_conv_valid || w_fire_seq) begin
            r_conv_valid <= w_fire_conv;
        end
        if (w_fire_conv) begin
            r_conv <= w_conv;
        end
    end

    // Stage three: sample timer, classing and the gate sequencer.
    logic [TICK_W-1:0]  r_sample_elapsed;
    logic [TICK_W-1:0]  r_hold_elapsed;
    t_seq_state         r_state;
    logic [ANGLE_W-1:0] r_angle;
    logic               r_drive_on;
    logic [MOIST_W-1:0] r_last_moist;
    logic [CLASS_W-1:0] r_last_class;
    t_out_item          r_out;

    logic [TICK_W-1:0]  n_sample_elapsed;
    logic [TICK_W-1:0]  n_hold_elapsed;
    t_seq_state         n_state;
    logic [ANGLE_W-1:0] n_angle;
    logic               n_drive_on;
    logic [MOIST_W-1:0] n_last_moist;
    logic [CLASS_W-1:0] n_last_class;
    logic               w_taken;
    logic [TICK_W-1:0]  w_now;
    logic [CLASS_W-1:0] w_class;

    always_comb begin
        if (r_conv < r_empty_lim) begin
            w_class = CLS_EMPTY;
        end else if (r_conv < r_dry_lim) begin
            w_class = CLS_DRY;
        end else if (r_conv <= r_wet_lim) begin
            w_class = CLS_SAFE;
        end else begin
            w_class = CLS_WET;
        end
    end

    always_comb begin
        n_hold_elapsed   = r_hold_elapsed;
        n_state          = r_state;
        n_angle          = r_angle;
        n_drive_on       = r_drive_on;
        n_last_moist     = r_last_moist;
        n_last_class     = r_last_class;

        // The hold count advances first while the gate is held.
        if (r_state == SEQ_SORTING && r_hold_elapsed != '1) begin
            n_hold_elapsed = r_hold_elapsed + 1'b1;
        end

        w_now   = (r_sample_elapsed == '1) ? r_sample_elapsed : r_sample_elapsed + 1'b1;
        w_taken = (w_now >= r_interval);
        n_sample_elapsed = w_taken ? '0 : w_now;

        if (w_taken) begin
            n_last_moist = r_conv;
            n_last_class = w_class;
            // An empty sample re-arms a finished sequence.
            if (w_class == CLS_EMPTY && n_state == SEQ_DONE) begin
                n_state = SEQ_IDLE;
            end
            if (w_class != CLS_EMPTY && n_state == SEQ_IDLE) begin
                n_drive_on = 1'b1;
                case (w_class)
                    CLS_WET: n_angle = ANGLE_RIGHT;
                    CLS_DRY: n_angle = ANGLE_LEFT;
                    default: n_angle = ANGLE_CENTER;
                endcase
                n_state        = SEQ_SORTING;
                n_hold_elapsed = '0;
            end
        end

        // Hold time over: return to center and release the servo.
        if (n_state == SEQ_SORTING && n_hold_elapsed >= r_hold_ticks) begin
            n_angle    = ANGLE_CENTER;
            n_drive_on = 1'b0;
            n_state    = SEQ_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_elapsed <= '1;
            r_hold_elapsed   <= '0;
            r_state          <= SEQ_IDLE;
            r_angle          <= ANGLE_CENTER;
            r_drive_on       <= 1'b0;
            r_last_moist     <= '0;
            r_last_class     <= CLS_EMPTY;
            r_out_valid      <= 1'b0;
        end else begin
            if (!r_out_valid || o_out.ready) begin
                r_out_valid <= w_fire_seq;
            end
            if (w_fire_seq) begin
                r_sample_elapsed <= n_sample_elapsed;
                r_hold_elapsed   <= n_hold_elapsed;
                r_state          <= n_state;
                r_angle          <= n_angle;
                r_drive_on       <= n_drive_on;
                r_last_moist     <= n_last_moist;
                r_last_class     <= n_last_class;
            end
        end
        if (w_fire_seq) begin
            r_out.servo_angle    <= n_angle;
            r_out.servo_enabled  <= n_drive_on;
            r_out.sample_taken   <= w_taken;
            r_out.moisture_q8    <= n_last_moist;
            r_out.moisture_class <= n_last_class;
            r_out.sort_state     <= n_state;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // The servo is driven only while a sort is in progress.
    a_drive_only_sorting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_drive_on |-> (r_state == SEQ_SORTING))
        else $error("servo drive on outside the sorting state");

    // A released servo always rests at center.
    a_center_when_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drive_on |-> (r_angle == ANGLE_CENTER))
        else $error("gate off center with the drive released");

    // A delivered result agrees with the sequencer about the drive.
    a_out_drive_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.servo_enabled) |-> (r_out.sort_state == SEQ_SORTING))
        else $error("result shows drive on outside sorting");

    // The sample timer moves only when an item passes the sequencer stage.
    a_timer_moves_on_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire_seq |=> $stable(r_sample_elapsed))
        else $error("sample timer changed without an item");
endmodule

FILE: hdl/msgc_conv.sv
// Linear converter from an ADC reading to clamped moisture in percent times 256.
module msgc_conv (
    input  msgc_pkg::t_conv_coef                  i_coef,
    input  logic [msgc_pkg::ADC_W-1:0]            i_adc,
    output logic [msgc_pkg::MOIST_W-1:0]          o_moisture_q8
);
    import msgc_pkg::*;

    logic signed [SUM_W-1:0] w_prod;
    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] w_rnd;

    assign w_prod = i_coef.gain_q16 * $signed({1'b0, i_adc});
    assign w_sum  = w_prod + SUM_W'(i_coef.offset_q16);
    assign w_rnd  = w_sum + SUM_W'(128);

    // Inside the open range the rounded value never exceeds full scale.
    always_comb begin
        if (w_sum <= SUM_W'(0)) begin
            o_moisture_q8 = '0;
        end else if (w_sum >= FULL_Q16) begin
            o_moisture_q8 = FULL_Q8;
        end else begin
            o_moisture_q8 = w_rnd[MOIST_W+7:8];
        end
    end
endmodule
